// ===== rtl/wrot_pkg.sv =====
// Package with the shared types and constants of the write range overlap tracker.
package wrot_pkg;

  localparam int OFFSET_W = 24;
  localparam int SIZE_W   = 25;
  localparam int COUNT_W  = 5;

  localparam logic [SIZE_W-1:0] LEN_MAX = {SIZE_W{1'b1}};

  typedef struct packed {
    logic [OFFSET_W-1:0] write_offset;
    logic [SIZE_W-1:0]   write_size;
  } in_word_t;

  typedef struct packed {
    logic               dirtied;
    logic               merged;
    logic [COUNT_W-1:0] range_count;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

endpackage

// ===== rtl/write_range_overlap_tracker_core.sv =====
// Top level of the write range overlap tracker: range table, scan sequencer and result register.
//
// Each input word is one buffer write (offset, size). The block keeps a table of the byte ranges
// written since the last discard and answers every write with one result word. A write that
// overlaps any stored range clears the table, becomes its only entry and reports dirtied. A write
// that overlaps nothing extends the highest-indexed stored range that ends exactly at its offset
// (the length saturates at the largest 25-bit value) and reports merged; otherwise it is appended
// as a new entry. If an append is needed while the table already holds MAX_RANGES entries, the
// table restarts with the new range and the result reports dirtied. The range_count field carries
// the low five bits of the number of stored ranges after the write. Timing: the table lives in a
// single-port memory that is read one entry per cycle, and one shared overlap comparator checks
// each entry as its data comes back. in_stall stays high from the accept of a word through the scan
// and the update state, so the block takes no new word until it is through with the last one; the
// scan stops early at the first overlap. The update cycle waits while the previous result is still
// stalled on the output, but a finished result never blocks acceptance of the next write. The table
// needs no clearing after reset: only entries below the stored range count are ever read.
module write_range_overlap_tracker_core #(
  parameter int MAX_RANGES  = 16,
  parameter int OFFSET_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  wrot_pkg::in_word_t    in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output wrot_pkg::out_word_t   out_data
);

  // Index into the table, count of stored ranges, and width of an end address formed without wrap.
  localparam int IDX_W   = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int CNT_W   = $clog2(MAX_RANGES + 1);
  localparam int LEN_W   = wrot_pkg::SIZE_W;
  localparam int SUM_W   = ((OFFSET_BITS > LEN_W) ? OFFSET_BITS : LEN_W) + 1;
  localparam int ENTRY_W = OFFSET_BITS + LEN_W;

  wrot_pkg::state_t state_r, state_nxt;

  // Range table: start in the upper bits, length in the lower bits of each entry.
  logic [ENTRY_W-1:0] mem [MAX_RANGES];
  logic [ENTRY_W-1:0] rd_data_r;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [ENTRY_W-1:0] wr_data;

  // Control state.
  logic [CNT_W-1:0]   used_r, used_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Per-write working registers.
  logic [OFFSET_BITS-1:0] o_r, o_nxt;
  logic [LEN_W-1:0]       n_r, n_nxt;
  logic [SUM_W-1:0]       oe_r, oe_nxt;
  logic [CNT_W-1:0]       scan_idx_r, scan_idx_nxt;
  logic [IDX_W-1:0]       cmp_idx_r, cmp_idx_nxt;
  logic                   cmp_vld_r, cmp_vld_nxt;
  logic                   dirty_r, dirty_nxt;
  logic                   found_r, found_nxt;
  logic [IDX_W-1:0]       adj_idx_r, adj_idx_nxt;
  logic [OFFSET_BITS-1:0] adj_start_r, adj_start_nxt;
  logic [LEN_W-1:0]       adj_len_r, adj_len_nxt;
  wrot_pkg::out_word_t    out_data_r, out_data_nxt;

  // Shared comparator on the entry just read.
  logic [OFFSET_BITS-1:0] rd_start;
  logic [LEN_W-1:0]       rd_len;
  logic [SUM_W-1:0]       s_ext;
  logic [SUM_W-1:0]       o_ext;
  logic [SUM_W-1:0]       se;
  logic                   overlap;
  logic                   adjacent;
  logic                   hit;
  logic                   issue;
  logic                   full;
  logic                   out_free;
  logic [LEN_W:0]         merge_sum;
  logic [LEN_W-1:0]       merge_len;

  assign rd_start = rd_data_r[ENTRY_W-1 -: OFFSET_BITS];
  assign rd_len   = rd_data_r[LEN_W-1:0];
  assign s_ext    = SUM_W'(rd_start);
  assign o_ext    = SUM_W'(o_r);
  assign se       = s_ext + SUM_W'(rd_len);

  // Two ranges conflict if either one's start lies inside the other, or either one's end
  // falls inside the other (end compared inclusively, start exclusively).
  assign overlap = ((s_ext <= o_ext) && (o_ext < se)) ||
                   ((s_ext < oe_r) && (oe_r <= se)) ||
                   ((o_ext <= s_ext) && (s_ext < oe_r)) ||
                   ((o_ext < se) && (se <= oe_r));
  assign adjacent = (se == o_ext);

  assign hit      = cmp_vld_r && overlap;
  assign issue    = (scan_idx_r < used_r);
  assign full     = (used_r >= CNT_W'(MAX_RANGES));
  assign out_free = !out_valid_r || !out_stall;

  // Extending a range saturates its length rather than wrapping.
  assign merge_sum = {1'b0, adj_len_r} + {1'b0, n_r};
  assign merge_len = merge_sum[LEN_W] ? wrot_pkg::LEN_MAX : merge_sum[LEN_W-1:0];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wrot_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = wrot_pkg::ST_SCAN;
        end
      end
      wrot_pkg::ST_SCAN: begin
        if (hit || !issue) begin
          state_nxt = wrot_pkg::ST_UPDATE;
        end
      end
      wrot_pkg::ST_UPDATE: begin
        if (out_free) begin
          state_nxt = wrot_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = wrot_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath and table access for each state.
  always_comb begin
    rd_en         = 1'b0;
    rd_addr       = scan_idx_r[IDX_W-1:0];
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = {o_r, n_r};
    used_nxt      = used_r;
    o_nxt         = o_r;
    n_nxt         = n_r;
    oe_nxt        = oe_r;
    scan_idx_nxt  = scan_idx_r;
    cmp_idx_nxt   = cmp_idx_r;
    cmp_vld_nxt   = cmp_vld_r;
    dirty_nxt     = dirty_r;
    found_nxt     = found_r;
    adj_idx_nxt   = adj_idx_r;
    adj_start_nxt = adj_start_r;
    adj_len_nxt   = adj_len_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      wrot_pkg::ST_IDLE: begin
        if (in_valid) begin
          o_nxt        = OFFSET_BITS'(in_data.write_offset);
          n_nxt        = in_data.write_size;
          oe_nxt       = SUM_W'(OFFSET_BITS'(in_data.write_offset)) +
                         SUM_W'(in_data.write_size);
          scan_idx_nxt = '0;
          cmp_vld_nxt  = 1'b0;
          dirty_nxt    = 1'b0;
          found_nxt    = 1'b0;
        end
      end
      wrot_pkg::ST_SCAN: begin
        if (hit) begin
          dirty_nxt   = 1'b1;
          cmp_vld_nxt = 1'b0;
        end else begin
          if (cmp_vld_r && adjacent) begin
            found_nxt     = 1'b1;
            adj_idx_nxt   = cmp_idx_r;
            adj_start_nxt = rd_start;
            adj_len_nxt   = rd_len;
          end
          if (issue) begin
            rd_en        = 1'b1;
            cmp_idx_nxt  = scan_idx_r[IDX_W-1:0];
            scan_idx_nxt = scan_idx_r + CNT_W'(1);
            cmp_vld_nxt  = 1'b1;
          end else begin
            cmp_vld_nxt  = 1'b0;
          end
        end
      end
      wrot_pkg::ST_UPDATE: begin
        if (out_free) begin
          wr_en         = 1'b1;
          out_valid_nxt = 1'b1;
          out_data_nxt.merged  = 1'b0;
          out_data_nxt.dirtied = 1'b0;
          if (dirty_r || (!found_r && full)) begin
            // Restart the table with this write as its only range.
            wr_addr              = '0;
            wr_data              = {o_r, n_r};
            used_nxt             = CNT_W'(1);
            out_data_nxt.dirtied = 1'b1;
          end else if (found_r) begin
            wr_addr             = adj_idx_r;
            wr_data             = {adj_start_r, merge_len};
            out_data_nxt.merged = 1'b1;
          end else begin
            wr_addr  = used_r[IDX_W-1:0];
            wr_data  = {o_r, n_r};
            used_nxt = used_r + CNT_W'(1);
          end
          out_data_nxt.range_count = wrot_pkg::COUNT_W'(used_nxt);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wrot_pkg::ST_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    o_r         <= o_nxt;
    n_r         <= n_nxt;
    oe_r        <= oe_nxt;
    scan_idx_r  <= scan_idx_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    cmp_vld_r   <= cmp_vld_nxt;
    dirty_r     <= dirty_nxt;
    found_r     <= found_nxt;
    adj_idx_r   <= adj_idx_nxt;
    adj_start_r <= adj_start_nxt;
    adj_len_r   <= adj_len_nxt;
    out_data_r  <= out_data_nxt;
  end

  // Single-port range table with registered read data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign in_stall  = (state_r != wrot_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/wrot_checker.sv =====
// Port-level assertion checker for the write range overlap tracker, with its bind statement.
module wrot_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input wrot_pkg::out_word_t out_data
);

  // A result that waits on a stalled output keeps its word.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result word changed or dropped");

  // The block works on one write at a time, so it is busy right after taking one.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again in the cycle after an accept");

  // A dirtied write leaves exactly one range and never counts as merged.
  a_dirty_restart: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.dirtied |-> !out_data.merged && (out_data.range_count == 5'd1))
    else $error("dirtied result with merged set or count other than one");

  // A new result appears only as the block finishes a write and becomes free again.
  a_result_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_stall)
    else $error("result appeared while the block was still busy");

endmodule

bind write_range_overlap_tracker_core wrot_checker u_wrot_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
